>>> rtl/core/bsc_pkg.sv
// shared types, constants and arithmetic helpers for the barometric compensation block
package bsc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // compensation constants
  localparam logic signed [28:0] B6_OFFSET  = 29'sd4000;
  localparam logic signed [12:0] P_X1_COEF  = 13'sd3038;
  localparam logic signed [13:0] P_X2_COEF  = -14'sd7357;
  localparam logic signed [43:0] P_OFFSET   = 44'sd3791;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic signed [63:0] B4_OFFSET  = 64'sd32768;
  localparam logic signed [63:0] TEMP_ROUND = 64'sd8;
  localparam logic signed [63:0] QUAD_ROUND = 64'sd2;

  // input item
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [19:0] pressure_pa;
    logic               divide_error;
  } out_t;

  // unpacked calibration set
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cal_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [17:0] x1;
    logic signed [18:0] den;
    logic [18:0]        up;
    logic               dz;
  } mq_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv2k(input logic signed [63:0] v,
                                                input int unsigned k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

  // saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  // saturate to 20-bit signed
  function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
    logic signed [19:0] r;
    if (v > 64'sd524287) r = 20'sh7ffff;
    else if (v < -64'sd524288) r = 20'sh80000;
    else r = 20'(v);
    return r;
  endfunction

endpackage

>>> rtl/core/bsc_fifo.sv
// small register queue with combinational head read
module bsc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wdata;
  end

endmodule

>>> rtl/core/bsc_div.sv
// pipelined unsigned restoring divider, two quotient bits per stage
module bsc_div #(
  parameter int N  = 28,
  parameter int M  = 19,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  in_a,
  input  logic [M-1:0]  in_b,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [N-1:0]  out_q,
  output logic [TW-1:0] out_tag
);

  localparam int S = N / 2;

  typedef struct packed {
    logic [N-1:0] a;
    logic [M-1:0] rem;
    logic [N-1:0] q;
  } dv_t;

  dv_t           st   [S];
  dv_t           st_n [S];
  logic [M-1:0]  bs   [S];
  logic [TW-1:0] tg   [S];
  logic [S-1:0]  vld;

  // two restoring steps
  function automatic dv_t radix4(input dv_t s, input logic [M-1:0] b);
    dv_t        r;
    logic [M:0] t;
    r = s;
    for (int j = 0; j < 2; j++) begin
      t   = {r.rem, r.a[N-1]};
      r.a = {r.a[N-2:0], 1'b0};
      if (t >= {1'b0, b}) begin
        r.rem = M'(t - {1'b0, b});
        r.q   = {r.q[N-2:0], 1'b1};
      end else begin
        r.rem = t[M-1:0];
        r.q   = {r.q[N-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // stage arithmetic
  always_comb begin
    dv_t init;
    init.a   = in_a;
    init.rem = '0;
    init.q   = '0;
    st_n[0]  = radix4(init, in_b);
    for (int k = 1; k < S; k++) begin
      st_n[k] = radix4(st[k-1], bs[k-1]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st_n[0];
      bs[0] <= in_b;
      tg[0] <= in_tag;
      for (int k = 1; k < S; k++) begin
        st[k] <= st_n[k];
        bs[k] <= bs[k-1];
        tg[k] <= tg[k-1];
      end
    end
  end

  assign out_valid = vld[S-1];
  assign out_q     = st[S-1].q;
  assign out_tag   = tg[S-1];

endmodule

>>> rtl/core/bsc_front.sv
// front part: accepts readings, computes x1 and the temperature divisor, flags zero divisor
module bsc_front (
  input  logic          clk,
  input  logic          rst,
  input  bsc_pkg::cal_t cal,
  input  logic          push,
  input  bsc_pkg::in_t  sample,
  output logic          full,
  input  logic          mq_full,
  output logic          mq_push,
  output bsc_pkg::mq_t  mq_data
);

  logic               adv;
  logic [2:0]         vld;
  logic [15:0]        f1_ut;
  logic [18:0]        f1_up;
  logic signed [32:0] f2_prod;
  logic [18:0]        f2_up;
  bsc_pkg::mq_t       f3;
  bsc_pkg::mq_t       f3_n;
  logic signed [16:0] diff;

  assign adv     = !(mq_full && vld[2]);
  assign full    = !adv;
  assign mq_push = vld[2] && !mq_full;
  assign mq_data = f3;

  // x1 and divisor from the registered product
  always_comb begin
    f3_n.x1  = 18'(bsc_pkg::sdiv2k(64'(f2_prod), 15));
    f3_n.den = 19'(f3_n.x1) + 19'(cal.md);
    f3_n.up  = f2_up;
    f3_n.dz  = (f3_n.den == '0);
  end

  assign diff = signed'({1'b0, f1_ut}) - signed'({1'b0, cal.ac6});

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], push};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ut   <= sample.raw_temperature;
      f1_up   <= 19'(sample.raw_pressure >> (4'd8 - 4'(cal.oss)));
      f2_prod <= 33'(diff) * 33'(signed'({1'b0, cal.ac5}));
      f2_up   <= f1_up;
      f3      <= f3_n;
    end
  end

endmodule

>>> rtl/core/bsc_back.sv
// back part: temperature and pressure datapath with two pipelined dividers
module bsc_back (
  input  logic          clk,
  input  logic          rst,
  input  bsc_pkg::cal_t cal,
  input  logic          mq_empty,
  input  bsc_pkg::mq_t  mq_data,
  output logic          mq_pop,
  input  logic          res_full,
  output logic          res_valid,
  output bsc_pkg::out_t res_data
);

  typedef struct packed {
    logic signed [17:0] x1;
    logic [18:0]        up;
    logic               dz;
    logic               neg;
  } t1_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               err;
    logic               hi;
  } t2_t;

  typedef struct packed {
    logic signed [17:0] x1;
    logic [18:0]        up;
    logic               dz;
    logic signed [27:0] b5;
    logic signed [23:0] tempr;
    logic signed [15:0] temp;
    logic signed [28:0] b6;
    logic signed [57:0] sqprod;
    logic signed [44:0] ac2b6;
    logic signed [44:0] ac3b6;
    logic [42:0]        sq;
    logic signed [34:0] x2p;
    logic signed [32:0] x1q;
    logic signed [59:0] b2sq;
    logic signed [59:0] b1sq;
    logic signed [48:0] x1p;
    logic signed [44:0] x2q;
    logic signed [49:0] x3;
    logic signed [45:0] xq;
    logic signed [50:0] t;
    logic signed [43:0] x3q;
    logic signed [53:0] b3;
    logic [31:0]        u;
    logic [16:0]        b4;
    logic [31:0]        d;
    logic [31:0]        b7;
  } pa_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               err;
    logic signed [31:0] p;
    logic signed [23:0] pd;
    logic signed [45:0] x2prod;
    logic signed [29:0] x2r;
    logic signed [47:0] sqp;
    logic signed [59:0] m;
    logic signed [43:0] sum;
    logic signed [43:0] pres;
  } pb_t;

  logic        adv;
  logic [15:0] mc_mag;
  logic [18:0] den_mag;
  t1_t         d1_tag_in;
  logic        d1_v;
  logic [27:0] d1_q;
  t1_t         d1_tag;
  pa_t         pa   [11];
  pa_t         pa_n [11];
  logic [10:0] pav;
  logic [31:0] d2_a;
  t2_t         d2_tag_in;
  logic        d2_v;
  logic [31:0] d2_q;
  t2_t         d2_tag;
  pb_t         pb   [6];
  pb_t         pb_n [6];
  logic [5:0]  pbv;
  bsc_pkg::out_t fin_n;

  assign adv    = !(res_full && res_valid);
  assign mq_pop = adv && !mq_empty;

  // temperature divider operands: magnitudes and quotient sign
  assign mc_mag  = cal.mc[15] ? 16'(-cal.mc) : 16'(cal.mc);
  assign den_mag = mq_data.den[18] ? 19'(-mq_data.den) : 19'(mq_data.den);
  always_comb begin
    d1_tag_in.x1  = mq_data.x1;
    d1_tag_in.up  = mq_data.up;
    d1_tag_in.dz  = mq_data.dz;
    d1_tag_in.neg = cal.mc[15] ^ mq_data.den[18];
  end

  bsc_div #(.N(28), .M(19), .TW($bits(t1_t))) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (mq_pop),
    .in_a      ({1'b0, mc_mag, 11'b0}),
    .in_b      (den_mag),
    .in_tag    (d1_tag_in),
    .out_valid (d1_v),
    .out_q     (d1_q),
    .out_tag   (d1_tag)
  );

  // pressure coefficient stages
  always_comb begin
    logic [47:0] p48;
    pa_n[0] = '0;
    for (int k = 1; k < 11; k++) pa_n[k] = pa[k-1];
    // b5 from signed quotient
    pa_n[0].x1 = d1_tag.x1;
    pa_n[0].up = d1_tag.up;
    pa_n[0].dz = d1_tag.dz;
    pa_n[0].b5 = 28'(d1_tag.x1) + (d1_tag.neg ? -signed'(d1_q) : signed'(d1_q));
    // temperature and b6
    pa_n[1].tempr = 24'(bsc_pkg::sdiv2k(64'(pa[0].b5) + bsc_pkg::TEMP_ROUND, 4));
    pa_n[1].b6    = 29'(pa[0].b5) - bsc_pkg::B6_OFFSET;
    // products of b6
    pa_n[2].sqprod = pa[1].b6 * pa[1].b6;
    pa_n[2].ac2b6  = cal.ac2 * pa[1].b6;
    pa_n[2].ac3b6  = cal.ac3 * pa[1].b6;
    pa_n[2].temp   = bsc_pkg::sat16(64'(pa[1].tempr));
    // scale products
    pa_n[3].sq  = 43'(pa[2].sqprod >>> 12);
    pa_n[3].x2p = 35'(bsc_pkg::sdiv2k(64'(pa[2].ac2b6), 11));
    pa_n[3].x1q = 33'(bsc_pkg::sdiv2k(64'(pa[2].ac3b6), 13));
    // products of the square term
    pa_n[4].b2sq = cal.b2 * signed'({1'b0, pa[3].sq});
    pa_n[4].b1sq = cal.b1 * signed'({1'b0, pa[3].sq});
    pa_n[5].x1p  = 49'(bsc_pkg::sdiv2k(64'(pa[4].b2sq), 11));
    pa_n[5].x2q  = 45'(bsc_pkg::sdiv2k(64'(pa[4].b1sq), 16));
    pa_n[6].x3   = 50'(pa[5].x1p) + 50'(pa[5].x2p);
    pa_n[6].xq   = 46'(pa[5].x1q) + 46'(pa[5].x2q);
    // b3 partial and x3 for b4
    pa_n[7].t   = (51'(cal.ac1) <<< 2) + 51'(pa[6].x3);
    pa_n[7].x3q = 44'(bsc_pkg::sdiv2k(64'(pa[6].xq) + bsc_pkg::QUAD_ROUND, 2));
    pa_n[8].b3  = 54'(bsc_pkg::sdiv2k((64'(pa[7].t) <<< cal.oss) + bsc_pkg::QUAD_ROUND, 2));
    pa_n[8].u   = 32'(64'(pa[7].x3q) + bsc_pkg::B4_OFFSET);
    // b4 wraps at 32 bits
    p48         = 48'(cal.ac4) * 48'(pa[8].u);
    pa_n[9].b4  = p48[31:15];
    pa_n[9].d   = 32'(pa[8].up) - pa[8].b3[31:0];
    // b7 and zero-divisor flag
    pa_n[10].b7 = pa[9].d * (bsc_pkg::B7_SCALE >> cal.oss);
    pa_n[10].dz = pa[9].dz || (pa[9].b4 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pav <= '0;
    end else if (adv) begin
      pav <= {pav[9:0], d1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 11; k++) pa[k] <= pa_n[k];
    end
  end

  // pressure divider operands
  assign d2_a = pa[10].b7[31] ? pa[10].b7 : {pa[10].b7[30:0], 1'b0};
  always_comb begin
    d2_tag_in.temp = pa[10].temp;
    d2_tag_in.err  = pa[10].dz;
    d2_tag_in.hi   = pa[10].b7[31];
  end

  bsc_div #(.N(32), .M(17), .TW($bits(t2_t))) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pav[10]),
    .in_a      (d2_a),
    .in_b      (pa[10].b4),
    .in_tag    (d2_tag_in),
    .out_valid (d2_v),
    .out_q     (d2_q),
    .out_tag   (d2_tag)
  );

  // final pressure correction stages
  always_comb begin
    pb_n[0] = '0;
    for (int k = 1; k < 6; k++) pb_n[k] = pb[k-1];
    pb_n[0].temp   = d2_tag.temp;
    pb_n[0].err    = d2_tag.err;
    pb_n[0].p      = signed'(d2_tag.hi ? {d2_q[30:0], 1'b0} : d2_q);
    pb_n[1].pd     = 24'(bsc_pkg::sdiv2k(64'(pb[0].p), 8));
    pb_n[1].x2prod = pb[0].p * bsc_pkg::P_X2_COEF;
    pb_n[2].sqp    = pb[1].pd * pb[1].pd;
    pb_n[2].x2r    = 30'(bsc_pkg::sdiv2k(64'(pb[1].x2prod), 16));
    pb_n[3].m      = pb[2].sqp * bsc_pkg::P_X1_COEF;
    pb_n[4].sum    = 44'(pb[3].m >>> 16) + 44'(pb[3].x2r) + bsc_pkg::P_OFFSET;
    pb_n[5].pres   = 44'(pb[4].p) + 44'(bsc_pkg::sdiv2k(64'(pb[4].sum), 4));
  end

  // saturation and error zeroing
  always_comb begin
    if (pb[5].err) begin
      fin_n.temperature_tenths = '0;
      fin_n.pressure_pa        = '0;
      fin_n.divide_error       = 1'b1;
    end else begin
      fin_n.temperature_tenths = pb[5].temp;
      fin_n.pressure_pa        = bsc_pkg::sat20(64'(pb[5].pres));
      fin_n.divide_error       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbv       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      pbv       <= {pbv[4:0], d2_v};
      res_valid <= pbv[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) pb[k] <= pb_n[k];
      res_data <= fin_n;
    end
  end

endmodule

>>> rtl/core/barometric_sensor_compensation.sv
// top level: calibration registers, front, mid queue, back and result queue
//
//  channel   signals                              transfer when
//  -------   ----------------------------------   --------------------
//  sample    push, full, sample                   push && !full
//  result    empty, pop, result                   pop && !empty
//  config    cfg_write, cfg_index, cfg_data       cfg_write
//
// one item per cycle sustained while the result queue is not full; both dividers are pipelined two bits per stage
// the path from push to empty low runs mainly through the 14-stage temperature
// divider and the 16-stage pressure divider
// rst is synchronous and clears all valid state and the calibration registers
// a stalled result queue holds the back pipeline; the mid queue lets the front keep taking items
module barometric_sensor_compensation #(
  parameter int MID_DEPTH = bsc_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = bsc_pkg::OUT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  bsc_pkg::in_t                    sample,
  output logic                            empty,
  input  logic                            pop,
  output bsc_pkg::out_t                   result,
  input  logic                            cfg_write,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [31:0]   cal_ac1_ac2;
  logic [31:0]   cal_ac3_ac4;
  logic [31:0]   cal_ac5_ac6;
  logic [31:0]   cal_b1_b2;
  logic [31:0]   cal_mc_md;
  logic [1:0]    oversampling;
  bsc_pkg::cal_t cal;
  logic          mq_full;
  logic          mq_empty;
  logic          mq_push;
  logic          mq_pop;
  bsc_pkg::mq_t  mq_wdata;
  bsc_pkg::mq_t  mq_rdata;
  logic          res_full;
  logic          res_valid;
  bsc_pkg::out_t res_data;

  // calibration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2  <= '0;
      cal_ac3_ac4  <= '0;
      cal_ac5_ac6  <= '0;
      cal_b1_b2    <= '0;
      cal_mc_md    <= '0;
      oversampling <= '0;
    end else if (cfg_write) begin
      unique case (bsc_pkg::reg_idx_t'(cfg_index))
        bsc_pkg::REG_AC1_AC2: cal_ac1_ac2  <= cfg_data;
        bsc_pkg::REG_AC3_AC4: cal_ac3_ac4  <= cfg_data;
        bsc_pkg::REG_AC5_AC6: cal_ac5_ac6  <= cfg_data;
        bsc_pkg::REG_B1_B2:   cal_b1_b2    <= cfg_data;
        bsc_pkg::REG_MC_MD:   cal_mc_md    <= cfg_data;
        bsc_pkg::REG_OSS:     oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // unpack coefficients
  always_comb begin
    cal.ac1 = signed'(cal_ac1_ac2[31:16]);
    cal.ac2 = signed'(cal_ac1_ac2[15:0]);
    cal.ac3 = signed'(cal_ac3_ac4[31:16]);
    cal.ac4 = cal_ac3_ac4[15:0];
    cal.ac5 = cal_ac5_ac6[31:16];
    cal.ac6 = cal_ac5_ac6[15:0];
    cal.b1  = signed'(cal_b1_b2[31:16]);
    cal.b2  = signed'(cal_b1_b2[15:0]);
    cal.mc  = signed'(cal_mc_md[31:16]);
    cal.md  = signed'(cal_mc_md[15:0]);
    cal.oss = oversampling;
  end

  bsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cal     (cal),
    .push    (push),
    .sample  (sample),
    .full    (full),
    .mq_full (mq_full),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  bsc_fifo #(.W($bits(bsc_pkg::mq_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (mq_push),
    .wdata (mq_wdata),
    .rd    (mq_pop),
    .rdata (mq_rdata),
    .full  (mq_full),
    .empty (mq_empty)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rdata),
    .mq_pop    (mq_pop),
    .res_full  (res_full),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  bsc_fifo #(.W($bits(bsc_pkg::out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_valid),
    .wdata (res_data),
    .rd    (pop),
    .rdata (result),
    .full  (res_full),
    .empty (empty)
  );

endmodule

>>> rtl/core/bsc_checker.sv
// port-level checker for the compensation block and its bind
module bsc_checker (
  input logic          clk,
  input logic          rst,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input bsc_pkg::out_t result
);

  logic [7:0] outstanding;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (!full && empty))
    else $error("block not idle after reset");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  // error results carry zero values
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.divide_error) |->
      (result.temperature_tenths == '0 && result.pressure_pa == '0))
    else $error("error result with nonzero fields");

  // no result without an item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (outstanding != '0))
    else $error("result transfer without a pending item");

endmodule

bind barometric_sensor_compensation bsc_checker u_chk (.*);

>>> dv/barometric_sensor_compensation_tb.sv
// self-checking testbench for the barometric compensation block
module barometric_sensor_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  bsc_pkg::in_t sample = '0;
  logic empty;
  logic pop = 1'b0;
  bsc_pkg::out_t result;
  logic cfg_write = 1'b0;
  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // calibration copy and expected results
  logic [31:0] cal_regs [0:4];
  logic [1:0] oss_reg;
  bsc_pkg::out_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int div_errors_seen = 0;
  bit pop_stall_long = 0;

  barometric_sensor_compensation dut (.*);

  always #5 clk = ~clk;

  // signed divide with truncation toward zero
  function automatic longint tdiv(input longint a, input longint b);
    longint q;
    q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // datasheet integer compensation
  function automatic bsc_pkg::out_t compensate(input bsc_pkg::in_t s);
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, den, b5, b6, b3, sq, p, temp, pres;
    logic [31:0] ac4, up, b4, b7, pu;
    bsc_pkg::out_t r;
    ac1 = longint'($signed(cal_regs[0][31:16]));
    ac2 = longint'($signed(cal_regs[0][15:0]));
    ac3 = longint'($signed(cal_regs[1][31:16]));
    ac4 = {16'd0, cal_regs[1][15:0]};
    ac5 = longint'(cal_regs[2][31:16]);
    ac6 = longint'(cal_regs[2][15:0]);
    b1 = longint'($signed(cal_regs[3][31:16]));
    b2 = longint'($signed(cal_regs[3][15:0]));
    mc = longint'($signed(cal_regs[4][31:16]));
    md = longint'($signed(cal_regs[4][15:0]));
    ut = longint'(s.raw_temperature);
    up = {8'd0, s.raw_pressure} >> (8 - oss_reg);
    r = '0;
    r.divide_error = 1'b1;
    x1 = tdiv((ut - ac6) * ac5, 32768);
    den = x1 + md;
    if (den == 0) return r;
    x2 = tdiv(mc * 2048, den);
    b5 = x1 + x2;
    temp = tdiv(b5 + 8, 16);
    b6 = b5 - 4000;
    sq = tdiv(b6 * b6, 4096);
    x3 = tdiv(b2 * sq, 2048) + tdiv(ac2 * b6, 2048);
    b3 = tdiv((ac1 * 4 + x3) * (longint'(1) << oss_reg) + 2, 4);
    x3 = tdiv(tdiv(ac3 * b6, 8192) + tdiv(b1 * sq, 65536) + 2, 4);
    b4 = (ac4 * 32'(x3 + 32768)) / 32'd32768;
    if (b4 == 0) return r;
    b7 = (up - 32'(b3)) * (32'd50000 >> oss_reg);
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else pu = (b7 / b4) * 32'd2;
    p = longint'($signed(pu));
    x1 = tdiv(p, 256) * tdiv(p, 256);
    x1 = tdiv(x1 * 3038, 65536);
    x2 = tdiv(-7357 * p, 65536);
    pres = p + tdiv(x1 + x2 + 3791, 16);
    r.temperature_tenths = 16'(sat(temp, -32768, 32767));
    r.pressure_pa = 20'(sat(pres, -524288, 524287));
    r.divide_error = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // register write while idle, with cfg_write low again before the task returns
  task automatic write_reg(input bsc_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == bsc_pkg::REG_OSS) oss_reg = val[1:0];
    else cal_regs[idx] = val;
    @(posedge clk);
  endtask

  task automatic write_cal(input logic [31:0] r0, r1, r2, r3, r4, input logic [1:0] oss);
    write_reg(bsc_pkg::REG_AC1_AC2, r0);
    write_reg(bsc_pkg::REG_AC3_AC4, r1);
    write_reg(bsc_pkg::REG_AC5_AC6, r2);
    write_reg(bsc_pkg::REG_B1_B2, r3);
    write_reg(bsc_pkg::REG_MC_MD, r4);
    write_reg(bsc_pkg::REG_OSS, {30'd0, oss});
  endtask

  // one sample transfer, with an optional random gap before it; push stays high between
  // back-to-back transfers
  task automatic send_sample(input logic [15:0] t, input logic [23:0] p, input bit gaps);
    int g;
    g = 0;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
    end
    if (g != 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    sample <= '{raw_temperature: t, raw_pressure: p};
    do @(posedge clk); while (full);
    expected_results.push_back(compensate('{raw_temperature: t, raw_pressure: p}));
    items_sent++;
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      bsc_pkg::out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (want.divide_error) div_errors_seen++;
        if (result.divide_error !== want.divide_error)
          report_mismatch("divide_error", result.divide_error, want.divide_error);
        if (result.temperature_tenths !== want.temperature_tenths)
          report_mismatch("temperature_tenths", result.temperature_tenths,
                          want.temperature_tenths);
        if (result.pressure_pa !== want.pressure_pa)
          report_mismatch("pressure_pa", result.pressure_pa, want.pressure_pa);
      end
    end
  end

  // random pop stalls, mostly short with some long ones
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else if (pop_stall_long) pop <= ($urandom_range(0, 15) == 0);
    else pop <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      pop_stall_long = ($urandom_range(0, 3) == 0);
    end
  end

  // datasheet example calibration
  localparam logic [31:0] EX_R0 = {16'sd408, -16'sd72};
  localparam logic [31:0] EX_R1 = {-16'sd14383, 16'd32741};
  localparam logic [31:0] EX_R2 = {16'd32757, 16'd23153};
  localparam logic [31:0] EX_R3 = {16'sd6190, 16'sd4};
  localparam logic [31:0] EX_R4 = {-16'sd8711, 16'sd2868};

  task automatic test_reset_defaults;
    // all-zero calibration: ac4 zero always gives a pressure divide error
    send_sample(16'd0, 24'd0, 0);
    send_sample(16'hffff, 24'hffffff, 0);
    drain();
  endtask

  task automatic test_directed;
    write_cal(EX_R0, EX_R1, EX_R2, EX_R3, EX_R4, 2'd0);
    send_sample(16'd27898, 24'd23843 << 8, 0);
    send_sample(16'd0, 24'd0, 0);
    send_sample(16'hffff, 24'hffffff, 0);
    send_sample(16'h5555, 24'haaaaaa, 0);
    send_sample(16'haaaa, 24'h555555, 0);
    drain();
    write_reg(bsc_pkg::REG_OSS, 32'd3);
    send_sample(16'd27898, 24'hffffff, 0);
    send_sample(16'd0, 24'h000001, 0);
    drain();
    // zero temperature divisor: ac5 zero and md zero
    write_cal(EX_R0, EX_R1, 32'h0000_1234, EX_R3, {-16'sd8711, 16'sd0}, 2'd1);
    send_sample(16'd100, 24'd12345, 0);
    drain();
    // extreme calibration values to push saturation and large quotients
    write_cal(32'h7fff_8000, 32'h8000_ffff, 32'hffff_ffff, 32'h7fff_8000, 32'h8000_7fff, 2'd3);
    send_sample(16'hffff, 24'hffffff, 0);
    send_sample(16'd0, 24'd0, 0);
    send_sample(16'h8000, 24'h800000, 0);
    drain();
    write_cal(32'h8000_7fff, 32'h7fff_0001, 32'h0001_0000, 32'h8000_7fff, 32'h7fff_8000, 2'd2);
    send_sample(16'hffff, 24'd0, 0);
    send_sample(16'd0, 24'hffffff, 0);
    send_sample(16'd1, 24'd1, 0);
    drain();
  endtask

  task automatic test_random_near_datasheet;
    for (int k = 0; k < 4; k++) begin
      write_cal(EX_R0 ^ $urandom_range(0, 32'h00ff00ff), EX_R1 ^ $urandom_range(0, 32'h00ff00ff),
                EX_R2 ^ $urandom_range(0, 32'h00ff00ff), EX_R3 ^ $urandom_range(0, 32'h00ff00ff),
                EX_R4 ^ $urandom_range(0, 32'h00ff00ff), k[1:0]);
      for (int n = 0; n < 125; n++)
        send_sample(16'($urandom_range(20000, 36000)), 24'($urandom), 1);
      drain();
    end
  endtask

  task automatic test_random_wide;
    for (int k = 0; k < 3; k++) begin
      write_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      for (int n = 0; n < 100; n++)
        send_sample(16'($urandom), 24'($urandom), 1);
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 5; i++) cal_regs[i] = '0;
    oss_reg = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_near_datasheet();
    test_random_wide();
    $display("covered %0d samples, %0d results, %0d with divide error", items_sent,
             results_seen, div_errors_seen);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
